FILE: hw/rtl/rcdc_pkg.sv
// Package for the Rabin content-defined chunker: cut reason codes, register
// indexes, defaults and the GF(2) helpers that build the fingerprint tables.
// No dependencies.
package rcdc_pkg;

  localparam int unsigned WINDOW_BYTES_DFLT = 48;

  localparam int unsigned PRINT_W = 63;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [63:0] POLY_BITS = 64'hbfe6b8a5bf378d83;

  localparam logic [15:0] MIN_CHUNK_RST = 16'd2048;
  localparam logic [15:0] MAX_CHUNK_RST = 16'd65535;
  localparam logic [31:0] ANCHOR_MASK_RST = 32'h0000_1FFF;
  localparam logic [31:0] ANCHOR_VALUE_RST = 32'h0000_0078;

  typedef enum logic [1:0] {
    CUT_ANCHOR = 2'd0,
    CUT_MAX    = 2'd1,
    CUT_END    = 2'd2
  } cut_reason_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CHUNK    = 2'd0,
    CFG_MAX_CHUNK    = 2'd1,
    CFG_ANCHOR_MASK  = 2'd2,
    CFG_ANCHOR_VALUE = 2'd3
  } cfg_index_t;

  // One row per bit of a byte; a table entry is the XOR of the rows selected.
  typedef logic [PRINT_W-1:0] basis_t [8];

  // Multiply by x modulo the polynomial; argument below 2^63.
  function automatic logic [63:0] times_x(logic [63:0] r);
    logic [63:0] s;
    s = {r[62:0], 1'b0};
    if (s[63]) begin
      s = s ^ POLY_BITS;
    end
    return s;
  endfunction

  // Rows of the reduction table: x^k * (x^63 mod P).
  function automatic basis_t t_basis();
    basis_t      rows;
    logic [63:0] v;
    v = {1'b0, POLY_BITS[62:0]};
    for (int k = 0; k < 8; k++) begin
      rows[k] = v[PRINT_W-1:0];
      v = times_x(v);
    end
    return rows;
  endfunction

  // Rows of the removal table: x^k * x^(8*(window-1)) mod P.
  function automatic basis_t u_basis(int unsigned window);
    basis_t      rows;
    logic [63:0] v;
    v = 64'd1;
    for (int j = 0; j < 8 * (int'(window) - 1); j++) begin
      v = times_x(v);
    end
    for (int k = 0; k < 8; k++) begin
      rows[k] = v[PRINT_W-1:0];
      v = times_x(v);
    end
    return rows;
  endfunction

  // Table lookup as a linear map: XOR the rows picked by the byte bits.
  function automatic logic [PRINT_W-1:0] fold(basis_t rows, logic [7:0] sel);
    logic [PRINT_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (sel[k]) begin
        acc = acc ^ rows[k];
      end
    end
    return acc;
  endfunction

endpackage

FILE: hw/rtl/rcdc_in_if.sv
// Input channel of the chunker: one data byte per word with an end flag.
// Depends on nothing.
interface rcdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

FILE: hw/rtl/rcdc_out_if.sv
// Result channel of the chunker: chunk length and cut reason per word.
// Depends on nothing.
interface rcdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] chunk_length;
  logic [1:0]  cut_reason;

  modport source (output valid, output chunk_length, output cut_reason, input ready);
  modport sink   (input valid, input chunk_length, input cut_reason, output ready);
endinterface

FILE: hw/rtl/rabin_content_defined_chunker.sv
// Rabin content-defined chunker, top level.
// Uses rcdc_pkg, rcdc_in_if and rcdc_out_if.
//
// Usage:
//   in_s carries one data byte per word plus an end-of-data flag. out_m
//   carries one word per chunk: its length in bytes and why it was cut
//   (anchor match, maximum length, end of data). The cfg_ port writes the
//   minimum and maximum chunk length, the anchor mask and the anchor value;
//   write it only while no word is in flight.
//   A byte is accepted into an input register; once the output register is
//   free, the rolling fingerprint and the byte count are updated in one pass
//   and any cut is placed in the output register, which drives out_m. One
//   byte is taken per cycle while out_m does not stall; the fingerprint/count
//   update is combinational in a single pass, which sets that rate.
//   When out_m stalls with a result held, one more byte is taken into the
//   input register and then in_s.ready drops until the result leaves.
//   Reset (rst_n low at a clock edge) empties both registers, clears the
//   fingerprint and the count and loads the register defaults. The window
//   line needs no clearing: bytes older than the current chunk are masked
//   by the count.
module rabin_content_defined_chunker
  import rcdc_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rcdc_in_if.sink               in_s,
  rcdc_out_if.source            out_m,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam basis_t U_ROWS = u_basis(WINDOW_BYTES);
  localparam basis_t T_ROWS = t_basis();

  // configuration
  logic [15:0] min_chunk_r;
  logic [15:0] max_chunk_r;
  logic [31:0] anchor_mask_r;
  logic [31:0] anchor_value_r;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_end_r;

  // chunk state
  logic [7:0]          win_r [WINDOW_BYTES];
  logic [PRINT_W-1:0]  print_r;
  logic [PRINT_W-1:0]  print_nxt;
  logic [COUNT_W-1:0]  count_r;
  logic [COUNT_W-1:0]  count_nxt;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_len_r;
  cut_reason_t        out_reason_r;

  logic               out_free;
  logic               advance;
  logic [7:0]         old_byte;
  logic [PRINT_W-1:0] fp_rm;
  logic [7:0]         top_byte;
  logic [PRINT_W-1:0] fp_new;
  logic [COUNT_W-1:0] count_inc;
  logic               anchor_hit;
  logic               max_hit;
  logic               cut;
  cut_reason_t        reason;

  assign out_free = !out_valid_r || out_m.ready;
  assign advance  = s1_valid_r && out_free;
  assign in_s.ready = !s1_valid_r || out_free;

  // Outgoing byte counts only if it was written within the current chunk.
  assign old_byte = (count_r >= COUNT_W'(WINDOW_BYTES)) ? win_r[WINDOW_BYTES-1] : 8'd0;

  always_comb begin
    fp_rm      = print_r ^ fold(U_ROWS, old_byte);
    top_byte   = fp_rm[PRINT_W-1 -: 8];
    fp_new     = {fp_rm[PRINT_W-9:0], s1_byte_r} ^ fold(T_ROWS, top_byte);
    count_inc  = count_r + COUNT_W'(1);
    anchor_hit = ((fp_new[31:0] & anchor_mask_r) == anchor_value_r) &&
                 (count_inc >= min_chunk_r);
    max_hit    = count_inc >= max_chunk_r;
    cut        = anchor_hit || max_hit || s1_end_r;
    if (anchor_hit) begin
      reason = CUT_ANCHOR;
    end else if (max_hit) begin
      reason = CUT_MAX;
    end else begin
      reason = CUT_END;
    end
  end

  always_comb begin
    print_nxt = print_r;
    count_nxt = count_r;
    if (advance) begin
      print_nxt = cut ? '0 : fp_new;
      count_nxt = cut ? '0 : count_inc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_chunk_r    <= MIN_CHUNK_RST;
      max_chunk_r    <= MAX_CHUNK_RST;
      anchor_mask_r  <= ANCHOR_MASK_RST;
      anchor_value_r <= ANCHOR_VALUE_RST;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      print_r        <= '0;
      count_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_CHUNK:    min_chunk_r    <= cfg_data[15:0];
          CFG_MAX_CHUNK:    max_chunk_r    <= cfg_data[15:0];
          CFG_ANCHOR_MASK:  anchor_mask_r  <= cfg_data;
          CFG_ANCHOR_VALUE: anchor_value_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_s.ready) begin
        s1_valid_r <= in_s.valid;
      end
      if (out_free) begin
        out_valid_r <= advance && cut;
      end
      print_r <= print_nxt;
      count_r <= count_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      s1_byte_r <= in_s.data_byte;
      s1_end_r  <= in_s.end_of_data;
    end
    if (advance) begin
      win_r[0] <= s1_byte_r;
      for (int i = 1; i < int'(WINDOW_BYTES); i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
    if (advance && cut) begin
      out_len_r    <= count_inc;
      out_reason_r <= reason;
    end
  end

  assign out_m.valid        = out_valid_r;
  assign out_m.chunk_length = out_len_r;
  assign out_m.cut_reason   = out_reason_r;

endmodule

FILE: verif/testbench.sv
// Self-checking bench for rabin_content_defined_chunker: streams bytes, predicts
// each chunk cut with its own rolling fingerprint and compares every result word.
// Depends on rcdc_pkg, rcdc_in_if, rcdc_out_if and the chunker RTL.
`timescale 1ns / 1ps

module testbench;
  import rcdc_pkg::*;

  localparam int unsigned WIN = WINDOW_BYTES_DFLT;
  localparam logic [63:0] FP_POLY = 64'hbfe6b8a5bf378d83;
  localparam logic [63:0] FP_LOW63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [15:0] length;
    cut_reason_t reason;
  } chunk_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rcdc_in_if  in_if ();
  rcdc_out_if out_if ();

  rabin_content_defined_chunker #(
    .WINDOW_BYTES (WIN)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: fold/drop tables, window, fingerprint, count, registers.
  logic [63:0] fold_tab [256];
  logic [63:0] drop_tab [256];
  logic [7:0]  win_bytes [WIN];
  int unsigned win_ptr;
  logic [62:0] print_reg;
  logic [15:0] byte_count;
  logic [15:0] min_len;
  logic [15:0] max_len;
  logic [31:0] anchor_mask;
  logic [31:0] anchor_value;

  chunk_t pending_chunks [$];
  int     fail_count;
  bit     no_idle;

  function automatic logic [63:0] gf_times_x(logic [63:0] r);
    logic [63:0] s;
    s = r << 1;
    if (s[63]) begin
      s = s ^ FP_POLY;
    end
    return s;
  endfunction

  function automatic logic [63:0] gf_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = gf_times_x(r);
      if (a[i]) begin
        r = r ^ b;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic clear_chunk();
    for (int i = 0; i < WIN; i++) begin
      win_bytes[i] = 8'd0;
    end
    print_reg = '0;
    byte_count = '0;
  endtask

  // Roll one byte into the fingerprint and queue the cut it causes, if any.
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [63:0] fp;
    logic [7:0]  outgoing;
    logic [7:0]  top;
    logic [15:0] cnt;
    chunk_t      c;
    bit          cut;
    win_ptr = (win_ptr + 1) % WIN;
    outgoing = win_bytes[win_ptr];
    win_bytes[win_ptr] = b;
    fp = ({1'b0, print_reg} ^ drop_tab[outgoing]) & FP_LOW63;
    top = fp[62:55];
    fp = ((fp << 8) | {56'd0, b}) ^ fold_tab[top];
    print_reg = fp[62:0];
    cnt = byte_count + 16'd1;
    byte_count = cnt;
    cut = 1'b1;
    if ((print_reg[31:0] & anchor_mask) == anchor_value && cnt >= min_len) begin
      c.reason = CUT_ANCHOR;
    end else if (cnt >= max_len) begin
      c.reason = CUT_MAX;
    end else if (last) begin
      c.reason = CUT_END;
    end else begin
      cut = 1'b0;
    end
    if (cut) begin
      c.length = cnt;
      pending_chunks.push_back(c);
      clear_chunk();
    end
  endtask

  // Keep valid high across back-to-back words; drop it only for a gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_data <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    absorb_byte(b, last);
  endtask

  // Bytes that cause no cut may still sit in the pipeline: pad past its depth.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Upper bits of the 16-bit registers get junk that must be dropped.
  task automatic load_config(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [31:0] m, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MIN_CHUNK;
    cfg_data <= {16'($urandom), lo};
    @(posedge clk);
    cfg_index <= CFG_MAX_CHUNK;
    cfg_data <= {16'($urandom), hi};
    @(posedge clk);
    cfg_index <= CFG_ANCHOR_MASK;
    cfg_data <= m;
    @(posedge clk);
    cfg_index <= CFG_ANCHOR_VALUE;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    min_len = lo;
    max_len = hi;
    anchor_mask = m;
    anchor_value = v;
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
  endtask

  // Maximum of zero with the minimum above it: every byte is its own chunk.
  task automatic test_zero_max();
    load_config(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_idle();
  endtask

  // Anchor, maximum and end all apply at once; the anchor wins.
  task automatic test_anchor_priority();
    load_config(16'h0000, 16'h0001, 32'h0, 32'h0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_idle();
  endtask

  // Minimum above maximum: anchors never cut, maximum beats end of data.
  task automatic test_max_over_end();
    load_config(16'hFFFF, 16'h0002, 32'h0, 32'h0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h33, 1'b1);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    wait_idle();
  endtask

  // Chunk well past the window at full rate, ended by the maximum.
  task automatic test_count_limit();
    no_idle = 1'b1;
    load_config(16'hFFFF, 16'd100, 32'hFFFF_FFFF, $urandom);
    repeat (100) send_byte(8'($urandom), 1'b0);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [31:0] m;
    int          n;
    int          end_odds;
    for (int p = 0; p < 8; p++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      n = 25;
      end_odds = 16;
      case (p % 4)
        0: begin
          m = $urandom & 32'h0000_000F;
          load_config(16'($urandom_range(0, 8)), 16'($urandom_range(1, 40)), m, $urandom & m);
        end
        1: begin
          // Chunks past the window length exercise the outgoing-byte removal.
          m = 32'h0000_003F;
          n = 70;
          end_odds = 200;
          load_config(16'($urandom_range(48, 120)), 16'($urandom_range(150, 400)), m,
                      $urandom & m);
        end
        2: begin
          load_config(16'($urandom), 16'($urandom), $urandom, $urandom);
        end
        default: begin
          m = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
          load_config($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                      16'($urandom_range(0, 1) ? 65535 : $urandom_range(0, 1)), m,
                      $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
        end
      endcase
      repeat (n) send_byte(8'($urandom), $urandom_range(1, end_odds) == 1);
      wait_idle();
    end
    no_idle = 1'b0;
  endtask

  // Check each accepted result word and drive ready with random stalls.
  initial begin : result_checker
    chunk_t c;
    int     stall_left;
    out_if.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_chunks.size() == 0) begin
          note_failure($sformatf("unexpected chunk: len %0d reason %0d",
                                 out_if.chunk_length, out_if.cut_reason));
        end else begin
          c = pending_chunks.pop_front();
          if (out_if.chunk_length !== c.length || out_if.cut_reason !== c.reason) begin
            note_failure($sformatf("chunk mismatch: expected len %0d reason %s, got len %0d reason %0d",
                                   c.length, c.reason.name(), out_if.chunk_length,
                                   out_if.cut_reason));
          end
        end
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : run_limit
    #6_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin : main
    logic [63:0] span;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_CHUNK;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'd0;
    in_if.end_of_data = 1'b0;
    fail_count = 0;
    no_idle = 1'b0;

    span = 64'd1;
    for (int j = 0; j < 8 * (WIN - 1); j++) begin
      span = gf_times_x(span);
    end
    for (int j = 0; j < 256; j++) begin
      fold_tab[j] = gf_mul(64'(j), FP_POLY & FP_LOW63) | (64'(j & 1) << 63);
      drop_tab[j] = gf_mul(64'(j), span);
    end
    min_len = 16'd2048;
    max_len = 16'd65535;
    anchor_mask = 32'h0000_1FFF;
    anchor_value = 32'h0000_0078;
    win_ptr = 0;
    clear_chunk();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_max();
    test_anchor_priority();
    test_max_over_end();
    test_count_limit();
    test_random_phases();

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
